### hdl/oms_pkg.sv
`timescale 1ns / 1ps
package oms_pkg;

    localparam int MAX_ITEMS_DEF = 64;
    localparam int LABEL_W       = 7;
    localparam int STACK_DEPTH   = 8;
    localparam int STACK_IDX_W   = $clog2(STACK_DEPTH);
    localparam int SP_W          = $clog2(STACK_DEPTH + 1);

    localparam logic OPER_START  = 1'b0;
    localparam logic OPER_ANSWER = 1'b1;

    localparam logic KIND_QUERY = 1'b0;
    localparam logic KIND_ORDER = 1'b1;

    localparam logic [1:0] STG_NEW     = 2'd0;
    localparam logic [1:0] STG_LEFT    = 2'd1;
    localparam logic [1:0] STG_MERGE   = 2'd2;
    localparam logic [1:0] STG_MERGING = 2'd3;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_INIT,
        ST_TOP,
        ST_P_RD_LO,
        ST_M_RD_L,
        ST_V_TOP,
        ST_V_RD_B,
        ST_MX_RD,
        ST_CHK,
        ST_WAIT,
        ST_ANS_B,
        ST_ANS_W,
        ST_RESOLVE,
        ST_SWAP2,
        ST_CP_WR,
        ST_CB_RD,
        ST_CB_WR,
        ST_E_RD,
        ST_E_OUT
    } t_state;

    typedef enum logic [1:0] {
        CTX_PAIR,
        CTX_MERGE,
        CTX_VERIFY
    } t_ctx;

    typedef enum logic [5:0] {
        OP_NONE,
        OP_START,
        OP_INIT_WR,
        OP_POP,
        OP_SPLIT_R,
        OP_SPLIT_L,
        OP_MERGE_INIT,
        OP_PAIR_RD_UP,
        OP_PAIR_RD_LO,
        OP_RD_RIGHT,
        OP_M_RD_L,
        OP_CP_LEFT,
        OP_CP_RIGHT,
        OP_CP_WR,
        OP_CB_START,
        OP_CB_RD,
        OP_CB_WR,
        OP_VSTART,
        OP_V_RD_A,
        OP_V_RD_B,
        OP_MX_RD_A,
        OP_SET_RES,
        OP_QUERY,
        OP_ANS,
        OP_WR_A_RD_B,
        OP_WR_B,
        OP_SWAP1,
        OP_SWAP2,
        OP_MERGE_TAKE,
        OP_VNEXT,
        OP_VFAIL,
        OP_EMIT_START,
        OP_E_RD,
        OP_E_OUT
    } t_op;

    typedef struct packed {
        logic       sp_empty;
        logic [1:0] stage;
        logic       range_le;
        logic       range_two;
        logic       lok;
        logic       rok;
        logic       cb_last;
        logic       k_last;
        logic       vdone;
        logic       known_lt;
        logic       known_gt;
        logic       res;
        logic       out_free;
        logic       out_empty;
    } t_status;

endpackage

### hdl/oms_in_if.sv
`timescale 1ns / 1ps
interface oms_in_if;
    logic valid;
    logic ready;
    logic operation;
    logic answer_yes;

    modport source (output valid, output operation, output answer_yes, input ready);
    modport sink (input valid, input operation, input answer_yes, output ready);
endinterface

### hdl/oms_out_if.sv
`timescale 1ns / 1ps
interface oms_out_if;
    logic                         valid;
    logic                         ready;
    logic                         kind;
    logic [oms_pkg::LABEL_W-1:0]  query_first;
    logic [oms_pkg::LABEL_W-1:0]  query_second;
    logic [oms_pkg::LABEL_W-1:0]  order_label;
    logic                         last;

    modport source (output valid, output kind, output query_first, output query_second,
                    output order_label, output last, input ready);
    modport sink (input valid, input kind, input query_first, input query_second,
                  input order_label, input last, output ready);
endinterface

### hdl/oms_ram.sv
`timescale 1ns / 1ps
module oms_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

### hdl/oms_ctrl.sv
`timescale 1ns / 1ps
module oms_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_in_operation,
    output logic             o_in_ready,
    input  oms_pkg::t_status i_status,
    output oms_pkg::t_op     o_op
);
    oms_pkg::t_state r_state, n_state;
    oms_pkg::t_ctx   r_ctx, n_ctx;
    logic            w_acc;

    assign o_in_ready = ((r_state == oms_pkg::ST_IDLE) || (r_state == oms_pkg::ST_WAIT))
                        && i_status.out_empty;
    assign w_acc = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= oms_pkg::ST_IDLE;
            r_ctx   <= oms_pkg::CTX_PAIR;
        end else begin
            r_state <= n_state;
            r_ctx   <= n_ctx;
        end
    end

    always_comb begin
        n_state = r_state;
        n_ctx   = r_ctx;
        o_op    = oms_pkg::OP_NONE;
        case (r_state)
            oms_pkg::ST_IDLE: begin
                if (w_acc && i_in_operation == oms_pkg::OPER_START) begin
                    o_op    = oms_pkg::OP_START;
                    n_state = oms_pkg::ST_INIT;
                end
            end
            oms_pkg::ST_WAIT: begin
                if (w_acc) begin
                    if (i_in_operation == oms_pkg::OPER_START) begin
                        o_op    = oms_pkg::OP_START;
                        n_state = oms_pkg::ST_INIT;
                    end else begin
                        o_op    = oms_pkg::OP_ANS;
                        n_state = oms_pkg::ST_ANS_B;
                    end
                end
            end
            oms_pkg::ST_INIT: begin
                o_op = oms_pkg::OP_INIT_WR;
                if (i_status.k_last) begin
                    n_state = oms_pkg::ST_TOP;
                end
            end
            oms_pkg::ST_TOP: begin
                if (i_status.sp_empty) begin
                    o_op    = oms_pkg::OP_VSTART;
                    n_state = oms_pkg::ST_V_TOP;
                end else begin
                    case (i_status.stage)
                        oms_pkg::STG_NEW: begin
                            if (i_status.range_le) begin
                                o_op = oms_pkg::OP_POP;
                            end else if (i_status.range_two) begin
                                o_op    = oms_pkg::OP_PAIR_RD_UP;
                                n_ctx   = oms_pkg::CTX_PAIR;
                                n_state = oms_pkg::ST_P_RD_LO;
                            end else begin
                                o_op = oms_pkg::OP_SPLIT_R;
                            end
                        end
                        oms_pkg::STG_LEFT:  o_op = oms_pkg::OP_SPLIT_L;
                        oms_pkg::STG_MERGE: o_op = oms_pkg::OP_MERGE_INIT;
                        default: begin
                            if (i_status.lok && i_status.rok) begin
                                o_op    = oms_pkg::OP_RD_RIGHT;
                                n_ctx   = oms_pkg::CTX_MERGE;
                                n_state = oms_pkg::ST_M_RD_L;
                            end else if (i_status.lok) begin
                                o_op    = oms_pkg::OP_CP_LEFT;
                                n_state = oms_pkg::ST_CP_WR;
                            end else if (i_status.rok) begin
                                o_op    = oms_pkg::OP_CP_RIGHT;
                                n_state = oms_pkg::ST_CP_WR;
                            end else begin
                                o_op    = oms_pkg::OP_CB_START;
                                n_state = oms_pkg::ST_CB_RD;
                            end
                        end
                    endcase
                end
            end
            oms_pkg::ST_P_RD_LO: begin
                o_op    = oms_pkg::OP_PAIR_RD_LO;
                n_state = oms_pkg::ST_MX_RD;
            end
            oms_pkg::ST_M_RD_L: begin
                o_op    = oms_pkg::OP_M_RD_L;
                n_state = oms_pkg::ST_MX_RD;
            end
            oms_pkg::ST_V_TOP: begin
                if (i_status.vdone) begin
                    o_op    = oms_pkg::OP_EMIT_START;
                    n_state = oms_pkg::ST_E_RD;
                end else begin
                    o_op    = oms_pkg::OP_V_RD_A;
                    n_ctx   = oms_pkg::CTX_VERIFY;
                    n_state = oms_pkg::ST_V_RD_B;
                end
            end
            oms_pkg::ST_V_RD_B: begin
                o_op    = oms_pkg::OP_V_RD_B;
                n_state = oms_pkg::ST_MX_RD;
            end
            oms_pkg::ST_MX_RD: begin
                o_op    = oms_pkg::OP_MX_RD_A;
                n_state = oms_pkg::ST_CHK;
            end
            oms_pkg::ST_CHK: begin
                if (i_status.known_lt || i_status.known_gt) begin
                    o_op    = oms_pkg::OP_SET_RES;
                    n_state = oms_pkg::ST_RESOLVE;
                end else begin
                    o_op    = oms_pkg::OP_QUERY;
                    n_state = oms_pkg::ST_WAIT;
                end
            end
            oms_pkg::ST_ANS_B: begin
                o_op    = oms_pkg::OP_WR_A_RD_B;
                n_state = oms_pkg::ST_ANS_W;
            end
            oms_pkg::ST_ANS_W: begin
                o_op    = oms_pkg::OP_WR_B;
                n_state = oms_pkg::ST_RESOLVE;
            end
            oms_pkg::ST_RESOLVE: begin
                case (r_ctx)
                    oms_pkg::CTX_PAIR: begin
                        if (i_status.res) begin
                            o_op    = oms_pkg::OP_SWAP1;
                            n_state = oms_pkg::ST_SWAP2;
                        end else begin
                            o_op    = oms_pkg::OP_POP;
                            n_state = oms_pkg::ST_TOP;
                        end
                    end
                    oms_pkg::CTX_MERGE: begin
                        o_op    = oms_pkg::OP_MERGE_TAKE;
                        n_state = oms_pkg::ST_TOP;
                    end
                    default: begin
                        if (i_status.res) begin
                            o_op    = oms_pkg::OP_VNEXT;
                            n_state = oms_pkg::ST_V_TOP;
                        end else begin
                            o_op    = oms_pkg::OP_VFAIL;
                            n_state = oms_pkg::ST_E_RD;
                        end
                    end
                endcase
            end
            oms_pkg::ST_SWAP2: begin
                o_op    = oms_pkg::OP_SWAP2;
                n_state = oms_pkg::ST_TOP;
            end
            oms_pkg::ST_CP_WR: begin
                o_op    = oms_pkg::OP_CP_WR;
                n_state = oms_pkg::ST_TOP;
            end
            oms_pkg::ST_CB_RD: begin
                o_op    = oms_pkg::OP_CB_RD;
                n_state = oms_pkg::ST_CB_WR;
            end
            oms_pkg::ST_CB_WR: begin
                o_op    = oms_pkg::OP_CB_WR;
                n_state = i_status.cb_last ? oms_pkg::ST_TOP : oms_pkg::ST_CB_RD;
            end
            oms_pkg::ST_E_RD: begin
                o_op    = oms_pkg::OP_E_RD;
                n_state = oms_pkg::ST_E_OUT;
            end
            oms_pkg::ST_E_OUT: begin
                if (i_status.out_free) begin
                    o_op    = oms_pkg::OP_E_OUT;
                    n_state = i_status.k_last ? oms_pkg::ST_IDLE : oms_pkg::ST_E_RD;
                end
            end
            default: n_state = oms_pkg::ST_IDLE;
        endcase
    end
endmodule

### hdl/oms_dp.sv
`timescale 1ns / 1ps
module oms_dp #(
    parameter int MAX_ITEMS = oms_pkg::MAX_ITEMS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  oms_pkg::t_op                i_op,
    input  logic                        i_answer_yes,
    input  logic                        i_cfg_we,
    input  logic [oms_pkg::LABEL_W-1:0] i_cfg_wdata,
    input  logic                        i_out_ready,
    output logic                        o_out_valid,
    output logic                        o_kind,
    output logic [oms_pkg::LABEL_W-1:0] o_query_first,
    output logic [oms_pkg::LABEL_W-1:0] o_query_second,
    output logic [oms_pkg::LABEL_W-1:0] o_order_label,
    output logic                        o_last,
    output oms_pkg::t_status            o_status
);
    localparam int AW  = $clog2(MAX_ITEMS);
    localparam int IW  = $clog2(MAX_ITEMS + 1);
    localparam int MW  = 2 * MAX_ITEMS;
    localparam int LW  = oms_pkg::LABEL_W;
    localparam int SD  = oms_pkg::STACK_DEPTH;
    localparam int TW  = oms_pkg::STACK_IDX_W;
    localparam int SPW = oms_pkg::SP_W;

    logic [LW-1:0]  r_item_count;
    logic [IW-1:0]  r_n, r_k, r_left, r_right, r_outi, r_vi;
    logic [SPW-1:0] r_sp;
    logic [AW-1:0]  r_stk_lo [SD];
    logic [AW-1:0]  r_stk_up [SD];
    logic [1:0]     r_stk_st [SD];
    logic [LW-1:0]  r_va, r_vb;
    logic           r_res, r_ok;
    logic [AW-1:0]  r_mx_raddr;
    logic [MAX_ITEMS-1:0] r_row_vld;
    logic           r_ov, r_kind, r_last;
    logic [LW-1:0]  r_qf, r_qs, r_lbl;

    logic [IW-1:0]  w_n_clamp, w_n_m1, w_vi_m1;
    logic [TW-1:0]  w_top, w_sp_idx;
    logic           w_can_push;
    logic [AW-1:0]  w_lo, w_up, w_mid, w_mid_p1, w_span;
    logic [AW:0]    w_sum;
    logic [1:0]     w_st;
    logic [LW-1:0]  w_k_label, w_va_m1, w_vb_m1;
    logic [AW-1:0]  w_ia, w_ib;
    logic [LW-1:0]  w_os_rd, w_mb_rd;
    logic [MW-1:0]  w_mx_rd, w_row, w_set_a, w_set_b;
    logic [MAX_ITEMS-1:0] w_lt_half, w_gt_half, w_bit_ia, w_bit_ib, w_zero;
    logic           w_k_last;

    logic           os_we, os_re, mb_we, mb_re, mx_we, mx_re;
    logic [AW-1:0]  os_waddr, os_raddr, mb_waddr, mb_raddr, mx_waddr, mx_raddr;
    logic [LW-1:0]  os_wdata, mb_wdata;
    logic [MW-1:0]  mx_wdata;

    always_comb begin
        if (r_item_count == '0) begin
            w_n_clamp = IW'(1);
        end else if (r_item_count > LW'(MAX_ITEMS)) begin
            w_n_clamp = IW'(MAX_ITEMS);
        end else begin
            w_n_clamp = r_item_count[IW-1:0];
        end
    end

    assign w_n_m1     = r_n - IW'(1);
    assign w_vi_m1    = r_vi - IW'(1);
    assign w_k_last   = (r_k == w_n_m1);
    assign w_top      = r_sp[TW-1:0] - TW'(1);
    assign w_sp_idx   = r_sp[TW-1:0];
    assign w_can_push = (r_sp < SPW'(SD));
    assign w_lo       = r_stk_lo[w_top];
    assign w_up       = r_stk_up[w_top];
    assign w_st       = r_stk_st[w_top];
    assign w_sum      = {1'b0, w_lo} + {1'b0, w_up};
    assign w_mid      = w_sum[AW:1];
    assign w_mid_p1   = w_mid + AW'(1);
    assign w_span     = w_up - w_lo;
    assign w_k_label  = LW'(r_k) + LW'(1);
    assign w_va_m1    = r_va - LW'(1);
    assign w_vb_m1    = r_vb - LW'(1);
    assign w_ia       = w_va_m1[AW-1:0];
    assign w_ib       = w_vb_m1[AW-1:0];

    // memoized comparisons: low half of a row marks "row < col", high half "col < row"
    assign w_zero    = '0;
    assign w_row     = r_row_vld[r_mx_raddr] ? w_mx_rd : '0;
    assign w_lt_half = w_row[MAX_ITEMS-1:0];
    assign w_gt_half = w_row[MW-1:MAX_ITEMS];
    assign w_bit_ia  = MAX_ITEMS'(1) << w_ia;
    assign w_bit_ib  = MAX_ITEMS'(1) << w_ib;
    assign w_set_a   = r_res ? {w_zero, w_bit_ib} : {w_bit_ib, w_zero};
    assign w_set_b   = r_res ? {w_bit_ia, w_zero} : {w_zero, w_bit_ia};

    always_comb begin
        os_we = 1'b0; os_waddr = w_lo; os_wdata = r_va;
        os_re = 1'b0; os_raddr = w_up;
        mb_we = 1'b0; mb_waddr = r_outi[AW-1:0]; mb_wdata = w_os_rd;
        mb_re = 1'b0; mb_raddr = r_k[AW-1:0];
        mx_we = 1'b0; mx_waddr = w_ia; mx_wdata = w_row | w_set_a;
        mx_re = 1'b0; mx_raddr = w_ia;
        case (i_op)
            oms_pkg::OP_INIT_WR: begin
                os_we = 1'b1; os_waddr = r_k[AW-1:0]; os_wdata = w_k_label;
            end
            oms_pkg::OP_SWAP1: begin
                os_we = 1'b1; os_waddr = w_up; os_wdata = r_vb;
            end
            oms_pkg::OP_SWAP2: begin
                os_we = 1'b1; os_waddr = w_lo; os_wdata = r_va;
            end
            oms_pkg::OP_CB_WR: begin
                os_we = 1'b1; os_waddr = w_lo + r_k[AW-1:0]; os_wdata = w_mb_rd;
            end
            oms_pkg::OP_PAIR_RD_UP: begin
                os_re = 1'b1; os_raddr = w_up;
            end
            oms_pkg::OP_PAIR_RD_LO: begin
                os_re = 1'b1; os_raddr = w_lo;
            end
            oms_pkg::OP_RD_RIGHT, oms_pkg::OP_CP_RIGHT: begin
                os_re = 1'b1; os_raddr = r_right[AW-1:0];
            end
            oms_pkg::OP_M_RD_L, oms_pkg::OP_CP_LEFT: begin
                os_re = 1'b1; os_raddr = r_left[AW-1:0];
            end
            oms_pkg::OP_V_RD_A: begin
                os_re = 1'b1; os_raddr = w_vi_m1[AW-1:0];
            end
            oms_pkg::OP_V_RD_B: begin
                os_re = 1'b1; os_raddr = r_vi[AW-1:0];
            end
            oms_pkg::OP_E_RD: begin
                os_re = 1'b1; os_raddr = r_k[AW-1:0];
            end
            oms_pkg::OP_CP_WR: begin
                mb_we = 1'b1; mb_wdata = w_os_rd;
            end
            oms_pkg::OP_MERGE_TAKE: begin
                mb_we = 1'b1; mb_wdata = r_res ? r_va : r_vb;
            end
            oms_pkg::OP_CB_RD: begin
                mb_re = 1'b1;
            end
            oms_pkg::OP_MX_RD_A, oms_pkg::OP_ANS: begin
                mx_re = 1'b1; mx_raddr = w_ia;
            end
            oms_pkg::OP_WR_A_RD_B: begin
                mx_we = 1'b1; mx_waddr = w_ia; mx_wdata = w_row | w_set_a;
                mx_re = 1'b1; mx_raddr = w_ib;
            end
            oms_pkg::OP_WR_B: begin
                mx_we = 1'b1; mx_waddr = w_ib; mx_wdata = w_row | w_set_b;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item_count <= LW'(1);
            r_sp         <= '0;
            r_row_vld    <= '0;
            r_ov         <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_item_count <= i_cfg_wdata;
            end
            if (i_out_ready && i_op != oms_pkg::OP_QUERY && i_op != oms_pkg::OP_E_OUT) begin
                r_ov <= 1'b0;
            end
            case (i_op)
                oms_pkg::OP_START: begin
                    r_n       <= w_n_clamp;
                    r_k       <= '0;
                    r_sp      <= '0;
                    r_row_vld <= '0;
                end
                oms_pkg::OP_INIT_WR: begin
                    r_k <= r_k + IW'(1);
                    if (w_k_last) begin
                        r_stk_lo[0] <= '0;
                        r_stk_up[0] <= w_n_m1[AW-1:0];
                        r_stk_st[0] <= oms_pkg::STG_NEW;
                        r_sp        <= SPW'(1);
                    end
                end
                oms_pkg::OP_POP, oms_pkg::OP_SWAP2: begin
                    r_sp <= r_sp - SPW'(1);
                end
                oms_pkg::OP_SPLIT_R: begin
                    r_stk_st[w_top] <= oms_pkg::STG_LEFT;
                    if (w_can_push) begin
                        r_stk_lo[w_sp_idx] <= w_mid_p1;
                        r_stk_up[w_sp_idx] <= w_up;
                        r_stk_st[w_sp_idx] <= oms_pkg::STG_NEW;
                        r_sp               <= r_sp + SPW'(1);
                    end
                end
                oms_pkg::OP_SPLIT_L: begin
                    r_stk_st[w_top] <= oms_pkg::STG_MERGE;
                    if (w_can_push) begin
                        r_stk_lo[w_sp_idx] <= w_lo;
                        r_stk_up[w_sp_idx] <= w_mid;
                        r_stk_st[w_sp_idx] <= oms_pkg::STG_NEW;
                        r_sp               <= r_sp + SPW'(1);
                    end
                end
                oms_pkg::OP_MERGE_INIT: begin
                    r_stk_st[w_top] <= oms_pkg::STG_MERGING;
                    r_left          <= IW'(w_lo);
                    r_right         <= IW'(w_mid) + IW'(1);
                    r_outi          <= '0;
                end
                oms_pkg::OP_CP_LEFT:  r_left  <= r_left + IW'(1);
                oms_pkg::OP_CP_RIGHT: r_right <= r_right + IW'(1);
                oms_pkg::OP_CP_WR:    r_outi  <= r_outi + IW'(1);
                oms_pkg::OP_MERGE_TAKE: begin
                    if (r_res) begin
                        r_right <= r_right + IW'(1);
                    end else begin
                        r_left <= r_left + IW'(1);
                    end
                    r_outi <= r_outi + IW'(1);
                end
                oms_pkg::OP_CB_START: r_k <= '0;
                oms_pkg::OP_CB_WR: begin
                    r_k <= r_k + IW'(1);
                    if (r_k == IW'(w_span)) begin
                        r_sp <= r_sp - SPW'(1);
                    end
                end
                oms_pkg::OP_PAIR_RD_LO, oms_pkg::OP_M_RD_L, oms_pkg::OP_V_RD_B: begin
                    r_va <= w_os_rd;
                end
                oms_pkg::OP_MX_RD_A: begin
                    r_vb       <= w_os_rd;
                    r_mx_raddr <= w_ia;
                end
                oms_pkg::OP_SET_RES: r_res <= w_lt_half[w_ib];
                oms_pkg::OP_ANS: begin
                    r_res      <= i_answer_yes;
                    r_mx_raddr <= w_ia;
                end
                oms_pkg::OP_WR_A_RD_B: begin
                    r_row_vld[w_ia] <= 1'b1;
                    r_mx_raddr      <= w_ib;
                end
                oms_pkg::OP_WR_B: r_row_vld[w_ib] <= 1'b1;
                oms_pkg::OP_VSTART: begin
                    r_vi <= IW'(1);
                    r_ok <= 1'b1;
                end
                oms_pkg::OP_VNEXT: r_vi <= r_vi + IW'(1);
                oms_pkg::OP_VFAIL: begin
                    r_ok <= 1'b0;
                    r_k  <= '0;
                end
                oms_pkg::OP_EMIT_START: r_k <= '0;
                oms_pkg::OP_QUERY: begin
                    r_ov   <= 1'b1;
                    r_kind <= oms_pkg::KIND_QUERY;
                    r_qf   <= r_va;
                    r_qs   <= r_vb;
                    r_lbl  <= '0;
                    r_last <= 1'b0;
                end
                oms_pkg::OP_E_OUT: begin
                    r_ov   <= 1'b1;
                    r_kind <= oms_pkg::KIND_ORDER;
                    r_qf   <= '0;
                    r_qs   <= '0;
                    r_lbl  <= r_ok ? w_os_rd : '0;
                    r_last <= w_k_last;
                    r_k    <= r_k + IW'(1);
                end
                default: ;
            endcase
        end
    end

    oms_ram #(.WIDTH(LW), .DEPTH(MAX_ITEMS)) u_order_ram (
        .i_clk   (i_clk),
        .i_we    (os_we),
        .i_waddr (os_waddr),
        .i_wdata (os_wdata),
        .i_re    (os_re),
        .i_raddr (os_raddr),
        .o_rdata (w_os_rd)
    );

    oms_ram #(.WIDTH(LW), .DEPTH(MAX_ITEMS)) u_merge_ram (
        .i_clk   (i_clk),
        .i_we    (mb_we),
        .i_waddr (mb_waddr),
        .i_wdata (mb_wdata),
        .i_re    (mb_re),
        .i_raddr (mb_raddr),
        .o_rdata (w_mb_rd)
    );

    oms_ram #(.WIDTH(MW), .DEPTH(MAX_ITEMS)) u_less_ram (
        .i_clk   (i_clk),
        .i_we    (mx_we),
        .i_waddr (mx_waddr),
        .i_wdata (mx_wdata),
        .i_re    (mx_re),
        .i_raddr (mx_raddr),
        .o_rdata (w_mx_rd)
    );

    always_comb begin
        o_status.sp_empty  = (r_sp == '0);
        o_status.stage     = w_st;
        o_status.range_le  = (w_up <= w_lo);
        o_status.range_two = (w_up > w_lo) && (w_span == AW'(1));
        o_status.lok       = (r_left <= IW'(w_mid));
        o_status.rok       = (r_right <= IW'(w_up));
        o_status.cb_last   = (r_k == IW'(w_span));
        o_status.k_last    = w_k_last;
        o_status.vdone     = (r_vi >= r_n);
        o_status.known_lt  = w_lt_half[w_ib];
        o_status.known_gt  = w_gt_half[w_ib];
        o_status.res       = r_res;
        o_status.out_free  = !r_ov || i_out_ready;
        o_status.out_empty = !r_ov;
    end

    assign o_out_valid    = r_ov;
    assign o_kind         = r_kind;
    assign o_query_first  = r_qf;
    assign o_query_second = r_qs;
    assign o_order_label  = r_lbl;
    assign o_last         = r_last;

    a_stack_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sp <= SPW'(SD))
        else $error("range stack overflow");

    a_query_labels: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_kind == oms_pkg::KIND_QUERY) |->
            (r_qf != '0 && r_qs != '0 && r_qf != r_qs))
        else $error("malformed query");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_op == oms_pkg::OP_QUERY || i_op == oms_pkg::OP_E_OUT) |-> (!r_ov || i_out_ready))
        else $error("output register overwritten");

endmodule

### hdl/oracle_merge_sort_core.sv
`timescale 1ns / 1ps
// Oracle-driven merge sort of labels 1..n, n taken from the item count register.
// Input channel i_in: operation START begins a new sort (abandoning any run);
// operation ANSWER delivers answer_yes for the outstanding query and is ignored
// when no query is pending. Output channel o_out: kind QUERY asks whether
// query_first < query_second; kind ORDER gives the sorted labels, one item per
// position, last set on the final one, labels all zero if the final check failed.
// Answers are memoized in a pairwise matrix RAM; known pairs are never asked again.
// A start seeds the order RAM with labels 1..n, then the sort walks its range stack;
// a comparison first looks up the matrix RAM, and a new answer is stored into it.
// Merged entries are copied back from the merge RAM, a final check then compares each
// adjacent pair, and the labels are emitted one entry at a time.
// One item is processed at a time; input ready is high only while idle or waiting
// for an answer, and only when the output register is empty.
// A stalled receiver holds the output register; the sequencer waits on it.
// Reset clears the sequencer, the matrix valid bits and the output register; the
// item count register resets to 1. Start clears the matrix valid bits at once.
module oracle_merge_sort_core #(
    parameter int MAX_ITEMS = oms_pkg::MAX_ITEMS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    oms_in_if.sink                      i_in,
    oms_out_if.source                   o_out,
    input  logic                        i_cfg_we,
    input  logic [oms_pkg::LABEL_W-1:0] i_cfg_wdata
);
    oms_pkg::t_op     w_op;
    oms_pkg::t_status w_status;

    oms_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in.valid),
        .i_in_operation (i_in.operation),
        .o_in_ready     (i_in.ready),
        .i_status       (w_status),
        .o_op           (w_op)
    );

    oms_dp #(.MAX_ITEMS(MAX_ITEMS)) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_op           (w_op),
        .i_answer_yes   (i_in.answer_yes),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_out_ready    (o_out.ready),
        .o_out_valid    (o_out.valid),
        .o_kind         (o_out.kind),
        .o_query_first  (o_out.query_first),
        .o_query_second (o_out.query_second),
        .o_order_label  (o_out.order_label),
        .o_last         (o_out.last),
        .o_status       (w_status)
    );
endmodule

### bench/oracle_merge_sort_core_tb.sv
`timescale 1ns / 1ps
module oracle_merge_sort_core_tb;

    localparam int LIMIT_CYCLES = 1500000;
    localparam int SETTLE_CYCLES = 700;
    localparam int LW = oms_pkg::LABEL_W;

    typedef enum int {
        SP_IDLE,
        SP_SORT,
        SP_VERIFY,
        SP_SORT_WAIT,
        SP_VERIFY_WAIT
    } t_sort_phase;

    typedef enum int {
        ORACLE_TRUE,
        ORACLE_RANDOM,
        ORACLE_ABORT,
        ORACLE_ALL_YES
    } t_oracle_style;

    typedef struct {
        logic          kind;
        logic [LW-1:0] first;
        logic [LW-1:0] second;
        logic [LW-1:0] label;
        logic          last;
    } t_sort_item;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [LW-1:0] i_cfg_wdata;

    oms_in_if  in_if ();
    oms_out_if out_if ();

    oracle_merge_sort_core DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_if),
        .o_out      (out_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata)
    );

    // sorter mirror
    logic [LW-1:0]      count_reg;
    int                 run_n;
    logic [LW-1:0]      order_mem [64];
    logic [LW-1:0]      merge_mem [64];
    logic [63:0]        less_seen [64];
    int                 rng_lo [8];
    int                 rng_up [8];
    int                 rng_stg [8];
    int                 rng_sp;
    int                 l_idx, r_idx, m_idx, v_idx;
    int                 ask_first, ask_second;
    bit                 in_order;
    t_sort_phase        phase;

    t_sort_item expected_q[$];
    int  errors = 0;
    int  items_sent = 0;
    int  burst_left = 0;
    int  cycles = 0;
    int  rank [1:64];

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic void push_range(int lo, int up);
        if (rng_sp < 8) begin
            rng_lo[rng_sp] = lo;
            rng_up[rng_sp] = up;
            rng_stg[rng_sp] = 0;
            rng_sp++;
        end
    endfunction

    // 1: a < b known, 0: b < a known, 2: must ask
    function automatic int lookup(int a, int b);
        int ia, ib;
        ia = (a - 1) & 63;
        ib = (b - 1) & 63;
        if (less_seen[ia][ib]) return 1;
        if (less_seen[ib][ia]) return 0;
        ask_first = a & 127;
        ask_second = b & 127;
        return 2;
    endfunction

    function automatic void post_query();
        t_sort_item e;
        e.kind = oms_pkg::KIND_QUERY;
        e.first = LW'(ask_first);
        e.second = LW'(ask_second);
        e.label = '0;
        e.last = 1'b0;
        expected_q.push_back(e);
    endfunction

    function automatic void post_order();
        t_sort_item e;
        for (int k = 0; k < run_n; k++) begin
            e.kind = oms_pkg::KIND_ORDER;
            e.first = '0;
            e.second = '0;
            e.label = in_order ? order_mem[k & 63] : '0;
            e.last = (k + 1 == run_n);
            expected_q.push_back(e);
        end
        phase = SP_IDLE;
    endfunction

    function automatic void advance_sort();
        int lo, up, mid, r, f;
        logic [LW-1:0] t;
        bit lok, rok;
        bit busy;
        busy = 1;
        while (busy) begin
            if (phase == SP_SORT) begin
                if (rng_sp == 0) begin
                    phase = SP_VERIFY;
                    v_idx = 1;
                    in_order = 1;
                end else begin
                    f = rng_sp - 1;
                    lo = rng_lo[f] & 63;
                    up = rng_up[f] & 63;
                    mid = (lo + up) / 2;
                    case (rng_stg[f])
                        0: begin
                            if (up <= lo) begin
                                rng_sp--;
                            end else if (up - lo == 1) begin
                                r = lookup(order_mem[up], order_mem[lo]);
                                if (r == 2) begin
                                    phase = SP_SORT_WAIT;
                                    post_query();
                                    busy = 0;
                                end else begin
                                    if (r == 1) begin
                                        t = order_mem[up];
                                        order_mem[up] = order_mem[lo];
                                        order_mem[lo] = t;
                                    end
                                    rng_sp--;
                                end
                            end else begin
                                rng_stg[f] = 1;
                                push_range(mid + 1, up);
                            end
                        end
                        1: begin
                            rng_stg[f] = 2;
                            push_range(lo, mid);
                        end
                        2: begin
                            l_idx = lo;
                            r_idx = mid + 1;
                            m_idx = 0;
                            rng_stg[f] = 3;
                        end
                        default: begin
                            lok = l_idx <= mid;
                            rok = r_idx <= up;
                            if (lok && rok) begin
                                r = lookup(order_mem[r_idx & 63], order_mem[l_idx & 63]);
                                if (r == 2) begin
                                    phase = SP_SORT_WAIT;
                                    post_query();
                                    busy = 0;
                                end else if (r == 1) begin
                                    merge_mem[m_idx & 63] = order_mem[r_idx & 63];
                                    r_idx++;
                                    m_idx++;
                                end else begin
                                    merge_mem[m_idx & 63] = order_mem[l_idx & 63];
                                    l_idx++;
                                    m_idx++;
                                end
                            end else if (lok) begin
                                merge_mem[m_idx & 63] = order_mem[l_idx & 63];
                                l_idx++;
                                m_idx++;
                            end else if (rok) begin
                                merge_mem[m_idx & 63] = order_mem[r_idx & 63];
                                r_idx++;
                                m_idx++;
                            end else begin
                                for (int k = 0; k <= up - lo; k++)
                                    order_mem[(lo + k) & 63] = merge_mem[k & 63];
                                rng_sp--;
                            end
                        end
                    endcase
                end
            end else if (phase == SP_VERIFY) begin
                if (v_idx >= run_n) begin
                    post_order();
                    busy = 0;
                end else begin
                    r = lookup(order_mem[(v_idx - 1) & 63], order_mem[v_idx & 63]);
                    if (r == 2) begin
                        phase = SP_VERIFY_WAIT;
                        post_query();
                        busy = 0;
                    end else if (r == 0) begin
                        in_order = 0;
                        post_order();
                        busy = 0;
                    end else begin
                        v_idx++;
                    end
                end
            end else begin
                busy = 0;
            end
        end
    endfunction

    function automatic void predict_item(logic op, logic yes);
        int n;
        if (op == oms_pkg::OPER_START) begin
            n = count_reg;
            if (n < 1) n = 1;
            if (n > 64) n = 64;
            run_n = n;
            for (int k = 0; k < 64; k++) less_seen[k] = '0;
            for (int k = 0; k < n; k++) order_mem[k] = LW'(k + 1);
            rng_sp = 0;
            push_range(0, n - 1);
            phase = SP_SORT;
            advance_sort();
        end else if (phase == SP_SORT_WAIT || phase == SP_VERIFY_WAIT) begin
            if (yes) less_seen[(ask_first - 1) & 63][(ask_second - 1) & 63] = 1'b1;
            else less_seen[(ask_second - 1) & 63][(ask_first - 1) & 63] = 1'b1;
            phase = (phase == SP_SORT_WAIT) ? SP_SORT : SP_VERIFY;
            advance_sort();
        end
    endfunction

    task automatic send_item(logic op, logic yes);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                in_if.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        in_if.valid <= 1'b1;
        in_if.operation <= op;
        in_if.answer_yes <= yes;
        do @(posedge i_clk); while (!in_if.ready);
        predict_item(op, yes);
        items_sent++;
    endtask

    task automatic drain_and_idle();
        in_if.valid <= 1'b0;
        burst_left = 0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_count(int value);
        drain_and_idle();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= LW'(value);
        @(posedge i_clk);
        count_reg = LW'(value);
        i_cfg_we <= 1'b0;
    endtask

    task automatic shuffle_ranks();
        int j, t;
        for (int k = 1; k <= 64; k++) rank[k] = k;
        for (int k = 64; k > 1; k--) begin
            j = $urandom_range(1, k);
            t = rank[k];
            rank[k] = rank[j];
            rank[j] = t;
        end
    endtask

    task automatic sort_run(t_oracle_style style);
        logic yes;
        int aborts;
        aborts = 0;
        shuffle_ranks();
        send_item(oms_pkg::OPER_START, 1'($urandom_range(0, 1)));
        while (phase == SP_SORT_WAIT || phase == SP_VERIFY_WAIT) begin
            if (style == ORACLE_ABORT && aborts < 2 && $urandom_range(0, 7) == 0) begin
                aborts++;
                send_item(oms_pkg::OPER_START, 1'($urandom_range(0, 1)));
            end else begin
                case (style)
                    ORACLE_RANDOM:  yes = 1'($urandom_range(0, 1));
                    ORACLE_ALL_YES: yes = 1'b1;
                    default:        yes = rank[ask_first & 63 ? ask_first : 64] <
                                          rank[ask_second & 63 ? ask_second : 64];
                endcase
                send_item(oms_pkg::OPER_ANSWER, yes);
            end
        end
    endtask

    task automatic test_directed();
        write_count(1);
        sort_run(ORACLE_TRUE);
        write_count(0);
        sort_run(ORACLE_TRUE);
        send_item(oms_pkg::OPER_ANSWER, 1'b1);
        send_item(oms_pkg::OPER_ANSWER, 1'b0);
        write_count(2);
        sort_run(ORACLE_ALL_YES);
        sort_run(ORACLE_RANDOM);
        write_count(3);
        sort_run(ORACLE_ABORT);
        sort_run(ORACLE_ALL_YES);
    endtask

    task automatic test_random_sorts();
        int n;
        while (items_sent < 360) begin
            n = ($urandom_range(0, 9) < 8) ? $urandom_range(2, 12) : $urandom_range(13, 40);
            write_count(n);
            sort_run(t_oracle_style'($urandom_range(0, 3)));
            if ($urandom_range(0, 4) == 0)
                send_item(oms_pkg::OPER_ANSWER, 1'($urandom_range(0, 1)));
        end
    endtask

    // count above the maximum runs a full-width sort
    task automatic test_full_width();
        write_count(127);
        sort_run(ORACLE_TRUE);
    endtask

    // receiver back-pressure
    int stall_mode = 0;
    int stall_left = 0;
    int mode_left = 0;
    always @(posedge i_clk) begin
        if (mode_left == 0) begin
            stall_mode <= $urandom_range(0, 3);
            mode_left <= $urandom_range(50, 300);
        end else begin
            mode_left <= mode_left - 1;
        end
        case (stall_mode)
            0: out_if.ready <= 1'b1;
            1: out_if.ready <= 1'($urandom_range(0, 1));
            2: out_if.ready <= (cycles % 4 == 0);
            default: begin
                if (stall_left == 0) begin
                    stall_left <= $urandom_range(1, 20);
                    out_if.ready <= ~out_if.ready;
                end else begin
                    stall_left <= stall_left - 1;
                end
            end
        endcase
    end

    always @(posedge i_clk) begin
        t_sort_item e;
        cycles <= cycles + 1;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (expected_q.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected item: kind %0d first %0d second %0d label %0d last %0d",
                             out_if.kind, out_if.query_first, out_if.query_second,
                             out_if.order_label, out_if.last);
            end else begin
                e = expected_q.pop_front();
                if (out_if.kind !== e.kind || out_if.query_first !== e.first ||
                    out_if.query_second !== e.second || out_if.order_label !== e.label ||
                    out_if.last !== e.last) begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: exp %0d/%0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d/%0d",
                                 e.kind, e.first, e.second, e.label, e.last,
                                 out_if.kind, out_if.query_first, out_if.query_second,
                                 out_if.order_label, out_if.last);
                end
            end
        end
        if (cycles > LIMIT_CYCLES) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        in_if.valid = 1'b0;
        in_if.operation = oms_pkg::OPER_ANSWER;
        in_if.answer_yes = 1'b0;
        out_if.ready = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        i_rst_n = 1'b0;
        count_reg = 1;
        run_n = 1;
        rng_sp = 0;
        phase = SP_IDLE;
        in_order = 1;
        ask_first = 0;
        ask_second = 0;
        for (int k = 0; k < 64; k++) less_seen[k] = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_full_width();
        test_random_sorts();
        drain_and_idle();
        if (errors == 0 && expected_q.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule

### filelist.f
hdl/oms_pkg.sv
hdl/oms_in_if.sv
hdl/oms_out_if.sv
hdl/oms_ram.sv
hdl/oms_ctrl.sv
hdl/oms_dp.sv
hdl/oracle_merge_sort_core.sv
bench/oracle_merge_sort_core_tb.sv
